@@ src/oar_pkg.sv @@
// Shared constants and types for the overlap-add reassembler.
// No dependencies; compiled first.
`default_nettype none

package oar_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int SUM_BITS           = SAMPLE_BITS + 6;
   localparam int CFG_BITS           = 7;
   localparam int MAX_WINDOW_DEFAULT = 64;
   localparam int QUEUE_DEPTH        = 4;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd64;
   localparam logic [CFG_BITS-1:0] HOP_RESET    = 7'd32;

   typedef enum logic {
      REG_WINDOW = 1'b0,
      REG_HOP    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] window_length;
      logic [CFG_BITS-1:0] hop_size;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/oar_req_if.sv @@
// Input channel: one complex section sample per word.
// Depends on oar_pkg.
`default_nettype none

interface oar_req_if;
   import oar_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_re;
   logic signed [SAMPLE_BITS-1:0] sample_im;
   logic                          last_sample;

   modport source (output valid, output sample_re, output sample_im, output last_sample,
                   input ready);
   modport sink   (input valid, input sample_re, input sample_im, input last_sample,
                   output ready);
endinterface

`default_nettype wire

@@ src/oar_rsp_if.sv @@
// Result channel: one reassembled complex output sample per word.
// Depends on oar_pkg.
`default_nettype none

interface oar_rsp_if;
   import oar_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] out_re;
   logic signed [SUM_BITS-1:0] out_im;
   logic                       last_out;

   modport source (output valid, output out_re, output out_im, output last_out,
                   input ready);
   modport sink   (input valid, input out_re, input out_im, input last_out,
                   output ready);
endinterface

`default_nettype wire

@@ src/oar_csr.sv @@
// Configuration registers (window length, hop size) behind an APB-style port.
// Depends on oar_pkg.
`default_nettype none

module oar_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [oar_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [oar_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [oar_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output oar_pkg::cfg_type                    cfg
);
   import oar_pkg::*;

   logic [CFG_BITS-1:0] window_ff, window_in;
   logic [CFG_BITS-1:0] hop_ff, hop_in;
   reg_index_type       index;
   logic                wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      window_in = window_ff;
      hop_in    = hop_ff;
      if (wr_en) begin
         case (index)
            REG_WINDOW: window_in = csr_pwdata[CFG_BITS-1:0];
            REG_HOP:    hop_in    = csr_pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         hop_ff    <= HOP_RESET;
      end else begin
         window_ff <= window_in;
         hop_ff    <= hop_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         REG_WINDOW: csr_prdata = CSR_DATA_BITS'(window_ff);
         REG_HOP:    csr_prdata = CSR_DATA_BITS'(hop_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.window_length = window_ff;
   assign cfg.hop_size      = hop_ff;

endmodule

`default_nettype wire

@@ src/oar_front.sv @@
// Front end: accepts sample words, tracks section position and buffer base,
// and classifies each word into a queue entry. Depends on oar_pkg, oar_req_if.
`default_nettype none

module oar_front #(
   parameter  int MAX_WINDOW = oar_pkg::MAX_WINDOW_DEFAULT,
   localparam int SW         = $clog2(MAX_WINDOW),
   localparam int EW         = 2 * oar_pkg::SAMPLE_BITS + 3 * SW + 3
) (
   input  logic             clock,
   input  logic             reset,
   input  oar_pkg::cfg_type cfg,
   oar_req_if.sink          req,
   output logic             q_valid,
   input  logic             q_ready,
   output logic [EW-1:0]    q_data
);
   import oar_pkg::*;

   localparam int AW = CFG_BITS + 1;
   localparam logic [CFG_BITS-1:0] MAXW = CFG_BITS'(MAX_WINDOW);
   localparam logic [AW-1:0]       MAXA = AW'(MAX_WINDOW);

   logic [SW-1:0]       k_ff, k_in;
   logic [SW-1:0]       base_ff, base_in;
   logic [CFG_BITS-1:0] win, hop;
   logic [AW-1:0]       slot_sum, slot_wrap, base_sum, base_wrap;
   logic [SW-1:0]       slot, next_base, fcount;
   logic                emit, flush_need, item_end, section_end, accept;

   always_comb begin
      win = cfg.window_length;
      if (win == '0) begin
         win = CFG_BITS'(1);
      end else if (win > MAXW) begin
         win = MAXW;
      end
      hop = cfg.hop_size;
      if (hop == '0) begin
         hop = CFG_BITS'(1);
      end else if (hop > win) begin
         hop = win;
      end
   end

   always_comb begin
      slot_sum  = AW'(base_ff) + AW'(k_ff);
      slot_wrap = (slot_sum >= MAXA) ? slot_sum - MAXA : slot_sum;
      slot      = slot_wrap[SW-1:0];
      base_sum  = AW'(base_ff) + AW'(hop);
      base_wrap = (base_sum >= MAXA) ? base_sum - MAXA : base_sum;
      next_base = base_wrap[SW-1:0];
   end

   assign emit        = CFG_BITS'(k_ff) < hop;
   assign flush_need  = req.last_sample && (hop < win);
   assign item_end    = req.last_sample && !flush_need;
   assign fcount      = SW'(win - hop);
   assign section_end = (AW'(k_ff) + AW'(1)) >= AW'(win);

   assign accept    = req.valid && q_ready;
   assign req.ready = q_ready;
   assign q_valid   = req.valid;
   assign q_data    = {req.sample_re, req.sample_im, slot, emit, item_end, flush_need,
                       next_base, fcount};

   always_comb begin
      k_in    = k_ff;
      base_in = base_ff;
      if (accept) begin
         if (req.last_sample) begin
            k_in    = '0;
            base_in = '0;
         end else if (section_end) begin
            k_in    = '0;
            base_in = next_base;
         end else begin
            k_in = k_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         base_ff <= '0;
      end else begin
         k_ff    <= k_in;
         base_ff <= base_in;
      end
   end

endmodule

`default_nettype wire

@@ src/oar_queue.sv @@
// Short word queue between the front end and the back end.
// Depends on oar_pkg for its default depth.
`default_nettype none

module oar_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = oar_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = store_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ src/oar_back.sv @@
// Back end: overlap buffer read-modify-write, end-of-channel flush sequencing
// and the result register. Depends on oar_pkg, oar_rsp_if.
`default_nettype none

module oar_back #(
   parameter  int MAX_WINDOW = oar_pkg::MAX_WINDOW_DEFAULT,
   localparam int SW         = $clog2(MAX_WINDOW),
   localparam int EW         = 2 * oar_pkg::SAMPLE_BITS + 3 * SW + 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_ready,
   input  logic [EW-1:0] q_data,
   oar_rsp_if.source     rsp
);
   import oar_pkg::*;

   localparam int XW = SUM_BITS - SAMPLE_BITS;

   // queue entry fields
   logic [SAMPLE_BITS-1:0] e_re, e_im;
   logic [SW-1:0]          e_slot, e_fstart, e_fcount;
   logic                   e_emit, e_end, e_flush;

   // flush sequencer
   logic          flushing_ff, flushing_in;
   logic [SW-1:0] faddr_ff, faddr_in;
   logic [SW-1:0] frem_ff, frem_in;

   // issued operation
   logic [SW-1:0]          op_addr;
   logic [SAMPLE_BITS-1:0] op_re, op_im;
   logic                   op_emit, op_last, op_avail, issue, s1_adv;

   // update stage
   logic                   s2_valid_ff;
   logic [SW-1:0]          s2_addr_ff;
   logic [SAMPLE_BITS-1:0] s2_re_ff, s2_im_ff;
   logic                   s2_emit_ff, s2_last_ff;
   logic                   adv2;

   // overlap buffer
   logic [2*SUM_BITS-1:0]  sum_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]  valid_ff;
   logic [2*SUM_BITS-1:0]  rd_ff;
   logic                   rdv_ff;
   logic                   fwd_ff;
   logic [2*SUM_BITS-1:0]  fwd_data_ff;
   logic [SUM_BITS-1:0]    old_re, old_im, new_re, new_im;

   // result register
   logic                   out_valid_ff;
   logic [SUM_BITS-1:0]    out_re_ff, out_im_ff;
   logic                   out_last_ff;
   logic                   out_free;

   assign {e_re, e_im, e_slot, e_emit, e_end, e_flush, e_fstart, e_fcount} = q_data;

   always_comb begin
      if (flushing_ff) begin
         op_addr = faddr_ff;
         op_re   = '0;
         op_im   = '0;
         op_emit = 1'b1;
         op_last = frem_ff == SW'(1);
      end else begin
         op_addr = e_slot;
         op_re   = e_re;
         op_im   = e_im;
         op_emit = e_emit;
         op_last = e_end;
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;
   assign adv2     = s2_valid_ff && (!s2_emit_ff || out_free);
   assign s1_adv   = !s2_valid_ff || adv2;
   assign op_avail = flushing_ff || q_valid;
   assign issue    = s1_adv && op_avail;
   assign q_ready  = s1_adv && !flushing_ff;

   always_comb begin
      flushing_in = flushing_ff;
      faddr_in    = faddr_ff;
      frem_in     = frem_ff;
      if (issue) begin
         if (flushing_ff) begin
            if (frem_ff == SW'(1)) begin
               flushing_in = 1'b0;
            end
            faddr_in = (faddr_ff == SW'(MAX_WINDOW - 1)) ? '0 : faddr_ff + SW'(1);
            frem_in  = frem_ff - SW'(1);
         end else if (e_flush) begin
            flushing_in = 1'b1;
            faddr_in    = e_fstart;
            frem_in     = e_fcount;
         end
      end
   end

   always_comb begin
      {old_re, old_im} = fwd_ff ? fwd_data_ff : (rdv_ff ? rd_ff : '0);
      new_re = old_re + {{XW{s2_re_ff[SAMPLE_BITS-1]}}, s2_re_ff};
      new_im = old_im + {{XW{s2_im_ff[SAMPLE_BITS-1]}}, s2_im_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flushing_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         valid_ff     <= '0;
      end else begin
         flushing_ff <= flushing_in;
         if (s1_adv) begin
            s2_valid_ff <= op_avail;
         end
         if (issue) begin
            fwd_ff <= adv2 && (s2_last_ff || (s2_addr_ff == op_addr));
         end
         if (adv2) begin
            if (s2_last_ff) begin
               valid_ff <= '0;
            end else begin
               valid_ff[s2_addr_ff] <= !s2_emit_ff;
            end
         end
         if (adv2 && s2_emit_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      faddr_ff <= faddr_in;
      frem_ff  <= frem_in;
      if (issue) begin
         s2_addr_ff  <= op_addr;
         s2_re_ff    <= op_re;
         s2_im_ff    <= op_im;
         s2_emit_ff  <= op_emit;
         s2_last_ff  <= op_last;
         rdv_ff      <= valid_ff[op_addr];
         fwd_data_ff <= (s2_last_ff || s2_emit_ff) ? '0 : {new_re, new_im};
      end
      if (adv2 && s2_emit_ff) begin
         out_re_ff   <= new_re;
         out_im_ff   <= new_im;
         out_last_ff <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= sum_mem[op_addr];
      end
      if (adv2 && !s2_emit_ff) begin
         sum_mem[s2_addr_ff] <= {new_re, new_im};
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_re   = out_re_ff;
   assign rsp.out_im   = out_im_ff;
   assign rsp.last_out = out_last_ff;

endmodule

`default_nettype wire

@@ src/overlap_add_reassembler.sv @@
// Overlap-add reassembler top level; depends on all files in src. A result word passes
// through the queue, update stage and result register; one sample word per cycle sustained
// unless results stall or a flush runs, set by the one-per-cycle read-modify-write of the
// overlap buffer. A last mark flushes each pending overlap slot (window - hop). Reset is
// synchronous and clears the buffer valid bits at once: no clearing pass.
`default_nettype none

module overlap_add_reassembler #(
   parameter int MAX_WINDOW = oar_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   oar_req_if.sink                           req_chan,
   oar_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [oar_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [oar_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [oar_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import oar_pkg::*;

   localparam int SW = $clog2(MAX_WINDOW);
   localparam int EW = 2 * SAMPLE_BITS + 3 * SW + 3;

   cfg_type       cfg;
   logic          fq_valid, fq_ready;
   logic [EW-1:0] fq_data;
   logic          bq_valid, bq_ready;
   logic [EW-1:0] bq_data;

   oar_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   oar_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req_chan),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_data  (fq_data)
   );

   oar_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   oar_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (bq_valid),
      .q_ready (bq_ready),
      .q_data  (bq_data),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the overlap-add reassembler: predicts every result word from
// the accepted sample words and the register writes, and checks the result stream against it.
// Depends on oar_pkg, oar_req_if, oar_rsp_if and overlap_add_reassembler.
`timescale 1ns / 100ps

class overlap_predictor;
   localparam int SB    = oar_pkg::SAMPLE_BITS;
   localparam int SUMB  = oar_pkg::SUM_BITS;
   localparam int SLOTS = oar_pkg::MAX_WINDOW_DEFAULT;

   typedef struct packed {
      logic [SUMB-1:0] re;
      logic [SUMB-1:0] im;
      logic            last;
   } out_word_type;

   logic [oar_pkg::CFG_BITS-1:0] window_reg;
   logic [oar_pkg::CFG_BITS-1:0] hop_reg;
   logic [SUMB-1:0]              acc_re [SLOTS];
   logic [SUMB-1:0]              acc_im [SLOTS];
   int unsigned                  pos;
   int unsigned                  base;
   out_word_type                 expected_words [$];
   int                           errors;

   function new();
      window_reg = oar_pkg::WINDOW_RESET;
      hop_reg    = oar_pkg::HOP_RESET;
      errors     = 0;
      clear_overlap();
   endfunction

   function void clear_overlap();
      for (int i = 0; i < SLOTS; i++) begin
         acc_re[i] = '0;
         acc_im[i] = '0;
      end
      pos  = 0;
      base = 0;
   endfunction

   function void write_reg(oar_pkg::reg_index_type idx, logic [oar_pkg::CFG_BITS-1:0] value);
      if (idx == oar_pkg::REG_WINDOW) window_reg = value;
      else hop_reg = value;
   endfunction

   function int unsigned cur_window();
      int unsigned w;
      w = window_reg;
      if (w < 1) w = 1;
      if (w > SLOTS) w = SLOTS;
      return w;
   endfunction

   function int unsigned cur_hop();
      int unsigned h;
      int unsigned w;
      w = cur_window();
      h = hop_reg;
      if (h < 1) h = 1;
      if (h > w) h = w;
      return h;
   endfunction

   function bit at_section_end();
      return pos + 1 >= cur_window();
   endfunction

   function void emit_slot(int unsigned slot, logic last);
      out_word_type word;
      word.re   = acc_re[slot];
      word.im   = acc_im[slot];
      word.last = last;
      expected_words.push_back(word);
      acc_re[slot] = '0;
      acc_im[slot] = '0;
   endfunction

   function void note_sample(logic [SB-1:0] re, logic [SB-1:0] im, logic last);
      int unsigned w;
      int unsigned h;
      int unsigned k;
      int unsigned slot;
      w    = cur_window();
      h    = cur_hop();
      k    = pos;
      slot = (base + k) % SLOTS;
      acc_re[slot] = acc_re[slot] + {{(SUMB-SB){re[SB-1]}}, re};
      acc_im[slot] = acc_im[slot] + {{(SUMB-SB){im[SB-1]}}, im};
      if (k < h) emit_slot(slot, last && h >= w);
      if (last) begin
         for (int unsigned p = h; p < w; p++) emit_slot((base + p) % SLOTS, p + 1 == w);
         clear_overlap();
      end else if (k + 1 >= w) begin
         pos  = 0;
         base = (base + h) % SLOTS;
      end else begin
         pos = k + 1;
      end
   endfunction

   function void check_word(logic [SUMB-1:0] re, logic [SUMB-1:0] im, logic last);
      out_word_type want;
      if (expected_words.size() == 0) begin
         errors++;
         $display("%0t: unexpected word re=%0d im=%0d last=%0d", $time,
                  $signed(re), $signed(im), last);
         return;
      end
      want = expected_words.pop_front();
      if (want.re !== re) begin
         errors++;
         $display("%0t: out_re mismatch expected %0d actual %0d", $time,
                  $signed(want.re), $signed(re));
      end
      if (want.im !== im) begin
         errors++;
         $display("%0t: out_im mismatch expected %0d actual %0d", $time,
                  $signed(want.im), $signed(im));
      end
      if (want.last !== last) begin
         errors++;
         $display("%0t: last_out mismatch expected %0d actual %0d", $time,
                  want.last, last);
      end
   endfunction
endclass

module tb_top;
   import oar_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int SETTLE_TICKS = 10;
   localparam int HOLD_TICKS   = 400;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_requests     = 0;
   int hold_served       = 0;
   int hold_left         = 0;
   int words_sent        = 0;
   int quiet_cycles      = 0;

   overlap_predictor predictor = new();

   oar_req_if req_if ();
   oar_rsp_if rsp_if ();

   overlap_add_reassembler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_word(input logic [SAMPLE_BITS-1:0] re, input logic [SAMPLE_BITS-1:0] im,
                            input logic last);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.sample_re   = re;
      req_if.sample_im   = im;
      req_if.last_sample = last;
      do @(posedge clock); while (!req_if.ready);
      predictor.note_sample(re, im, last);
      words_sent++;
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (predictor.expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_results_done();
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CFG_BITS-1:0] value);
      logic [31:0] noise;
      noise = $urandom;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {noise[CSR_DATA_BITS-1:CFG_BITS], value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      predictor.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'h7fff;
      if (r < 10) return 16'h8000;
      return 16'($urandom);
   endfunction

   task automatic pick_config();
      int r;
      int w;
      r = $urandom_range(99);
      if (r < 10) begin
         w = 64;
         csr_write(REG_WINDOW, 7'(w));
         csr_write(REG_HOP, 7'($urandom_range(64, 1)));
      end else if (r < 22) begin
         csr_write(REG_WINDOW, 7'($urandom_range(127)));
         csr_write(REG_HOP, 7'($urandom_range(127)));
      end else if (r < 35) begin
         csr_write(REG_HOP, 7'($urandom_range(12, 1)));
      end else begin
         w = $urandom_range(12, 1);
         csr_write(REG_WINDOW, 7'(w));
         if ($urandom_range(9) == 0) csr_write(REG_HOP, 7'($urandom_range(20, w)));
         else csr_write(REG_HOP, 7'($urandom_range(w, 1)));
      end
   endtask

   // return 1 when the channel was left open
   task automatic send_channel(output bit left_open);
      int kind;
      int sections;
      int count;
      bit boundary;
      kind      = $urandom_range(99);
      left_open = 1'b0;
      if (kind < 70) begin
         sections = (predictor.cur_window() > 16) ? $urandom_range(2, 1) : $urandom_range(4, 1);
         while (sections > 0) begin
            if ($urandom_range(49) == 0) wait_results_done();
            boundary = predictor.at_section_end();
            send_word(pick_sample(), pick_sample(), boundary && sections == 1);
            if (boundary) sections--;
         end
      end else begin
         count     = $urandom_range(2 * predictor.cur_window(), 1);
         left_open = (kind >= 88);
         for (int i = 0; i < count; i++)
            send_word(pick_sample(), pick_sample(), !left_open && i == count - 1);
      end
   endtask

   task automatic run_regime(input int s_pct, input int r_pct, input int target,
                             input bit squeeze);
      int  start;
      int  channels;
      bit  open;
      bit  first;
      sender_idle_pct   = s_pct;
      receiver_idle_pct = r_pct;
      start = words_sent;
      first = 1'b1;
      while (words_sent - start < target) begin
         settle();
         if (squeeze && first) begin
            csr_write(REG_WINDOW, 7'd6);
            csr_write(REG_HOP, 7'd6);
            hold_requests++;
         end else begin
            pick_config();
         end
         first    = 1'b0;
         channels = $urandom_range(3, 1);
         for (int c = 0; c < channels; c++) begin
            send_channel(open);
            if (open) break;
         end
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_left = HOLD_TICKS;
            hold_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         predictor.check_word(rsp_if.out_re, rsp_if.out_im, rsp_if.last_out);
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.sample_re   = '0;
      req_if.sample_im   = '0;
      req_if.last_sample = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // reset configuration, last mark early in a long section
      send_word(16'h7fff, 16'h8000, 1'b0);
      send_word(16'h8000, 16'h7fff, 1'b1);
      settle();

      csr_write(REG_WINDOW, 7'd4);
      csr_write(REG_HOP, 7'd2);
      send_word(16'h7fff, 16'h8000, 1'b0);
      send_word(16'h8000, 16'h7fff, 1'b0);
      send_word(16'h0000, 16'hffff, 1'b0);
      send_word(16'hffff, 16'h0000, 1'b0);
      send_word(16'h7fff, 16'h7fff, 1'b0);
      send_word(16'h8000, 16'h8000, 1'b0);
      send_word(16'h0001, 16'hffff, 1'b0);
      send_word(16'h5555, 16'haaaa, 1'b1);
      settle();

      // zero registers act as one
      csr_write(REG_WINDOW, 7'd0);
      csr_write(REG_HOP, 7'd0);
      send_word(16'h7fff, 16'h8000, 1'b0);
      send_word(16'h8000, 16'h0001, 1'b0);
      send_word(16'h1234, 16'hedcb, 1'b1);
      settle();

      // oversized registers clamp to the full window
      csr_write(REG_WINDOW, 7'd127);
      csr_write(REG_HOP, 7'd127);
      send_word(16'h8000, 16'h8000, 1'b0);
      send_word(16'h7fff, 16'h7fff, 1'b0);
      send_word(16'h00ff, 16'hff00, 1'b1);
      settle();

      // shrink the window mid-section
      csr_write(REG_WINDOW, 7'd5);
      csr_write(REG_HOP, 7'd3);
      send_word(16'h7fff, 16'h7fff, 1'b0);
      send_word(16'h7fff, 16'h8000, 1'b0);
      send_word(16'h4000, 16'hc000, 1'b0);
      settle();
      csr_write(REG_WINDOW, 7'd2);
      send_word(16'h2000, 16'he000, 1'b0);
      send_word(16'h8000, 16'h7fff, 1'b1);

      run_regime(28, 61, 165, 1'b0);
      run_regime(61, 28, 165, 1'b1);
      run_regime(0, 0, 170, 1'b1);

      settle();
      repeat (20) @(posedge clock);
      if (predictor.errors == 0 && predictor.expected_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
